>>> hw/rtl/assert_macros.svh
// Assertion shorthands for the list checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define ILIE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset.
`define ILIE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/ilie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ilie_pkg;

	localparam int unsigned ILIE_DEPTH = 16;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned POS_W      = 5;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned LEN_W      = 5;
	localparam int unsigned CNT_W      = $clog2(ILIE_DEPTH + 1);
	localparam int unsigned IDX_W      = $clog2(ILIE_DEPTH);
	localparam int unsigned CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

	typedef logic [WORD_W-1:0] word_t;

	// broadcast to every cell for one accepted beat
	typedef struct packed {
		logic             app;
		logic             ins;
		logic             era;
		logic [CMP_W-1:0] pos;
		logic [CMP_W-1:0] cnt;
	} cell_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/ilie_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ilie_cell (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ilie_pkg::cell_ctl_t    ctl,
	input  wire logic [ilie_pkg::IDX_W-1:0] idx,
	input  wire ilie_pkg::word_t        word_in,
	input  wire ilie_pkg::word_t        left,
	input  wire ilie_pkg::word_t        right,
	output ilie_pkg::word_t             value
);
	import ilie_pkg::*;

	word_t            val_q;
	word_t            val_nxt;
	logic [CMP_W-1:0] i_ext;
	logic [CMP_W-1:0] i_inc;

	assign i_ext = CMP_W'(idx);
	assign i_inc = i_ext + CMP_W'(1);

	always_comb begin
		val_nxt = val_q;
		if (ctl.app) begin
			if (i_ext == ctl.cnt) val_nxt = word_in;
		end else if (ctl.ins) begin
			if (i_ext == ctl.pos) begin
				val_nxt = word_in;
			end else if ((i_ext > ctl.pos) && (i_ext <= ctl.cnt)) begin
				val_nxt = left;
			end
		end else if (ctl.era) begin
			if ((i_ext >= ctl.pos) && (i_inc < ctl.cnt)) begin
				val_nxt = right;
			end else if (i_inc == ctl.cnt) begin
				val_nxt = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else begin
			val_q <= val_nxt;
		end
	end

	assign value = val_q;

endmodule
`default_nettype wire

>>> hw/rtl/indexed_list_insert_erase_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to ILIE_DEPTH signed 32-bit words: append, insert at an
// index, erase at an index (the freed top slot reads zero) or read. Each
// accepted beat gives one result beat, registered, in the next cycle; a new
// beat is taken every cycle while the result side keeps up, because the row
// of entry cells shifts all entries up or down together, all at once.
// Failed operations (list full, index out of range) change nothing, return
// ok low and word_out zero. length is the new entry count modulo 32.
module indexed_list_insert_erase_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ilie_pkg::KIND_W-1:0]   kind,
	input  wire logic [ilie_pkg::POS_W-1:0]    position,
	input  wire logic signed [ilie_pkg::WORD_W-1:0] word_in,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               ok,
	output logic signed [ilie_pkg::WORD_W-1:0] word_out,
	output logic [ilie_pkg::LEN_W-1:0]         length
);
	import ilie_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cnt_nxt;
	logic             out_valid_q;
	logic             ok_q;
	word_t            word_out_q;
	logic [LEN_W-1:0] length_q;

	logic             accept;
	logic             full;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic             in_range;
	logic             op_ok;
	word_t            rd_val;
	cell_ctl_t        ctl;
	word_t            cell_val [ILIE_DEPTH];

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign full     = (count_q == CNT_W'(ILIE_DEPTH));
	assign pos_ext  = CMP_W'(position);
	assign cnt_ext  = CMP_W'(count_q);
	assign in_range = (pos_ext < cnt_ext);

	always_comb begin
		op_ok   = 1'b0;
		cnt_nxt = count_q;
		case (kind)
			KIND_APPEND: begin
				op_ok = !full;
				if (op_ok) cnt_nxt = count_q + CNT_W'(1);
			end
			KIND_INSERT: begin
				op_ok = !full && (pos_ext <= cnt_ext);
				if (op_ok) cnt_nxt = count_q + CNT_W'(1);
			end
			KIND_ERASE: begin
				op_ok = in_range;
				if (op_ok) cnt_nxt = count_q - CNT_W'(1);
			end
			KIND_READ: begin
				op_ok = in_range;
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
	end

	assign ctl.app = accept && op_ok && (kind == KIND_APPEND);
	assign ctl.ins = accept && op_ok && (kind == KIND_INSERT);
	assign ctl.era = accept && op_ok && (kind == KIND_ERASE);
	assign ctl.pos = pos_ext;
	assign ctl.cnt = cnt_ext;

	for (genvar g = 0; g < ILIE_DEPTH; g++) begin : g_cell
		word_t left_w;
		word_t right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_val[g-1];
		end
		if (g == ILIE_DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_val[g+1];
		end
		ilie_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.idx     (IDX_W'(g)),
			.word_in (word_in),
			.left    (left_w),
			.right   (right_w),
			.value   (cell_val[g])
		);
	end

	assign rd_val = (kind == KIND_READ && in_range) ? cell_val[pos_ext[IDX_W-1:0]] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q       <= op_ok;
			word_out_q <= rd_val;
			length_q   <= LEN_W'(cnt_nxt);
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign word_out  = word_out_q;
	assign length    = length_q;

endmodule
`default_nettype wire

>>> hw/rtl/ilie_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ilie_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic                          ok,
	input wire logic signed [ilie_pkg::WORD_W-1:0] word_out,
	input wire logic [ilie_pkg::LEN_W-1:0]    length
);
	import ilie_pkg::*;

	`ILIE_ASSERT_NEXT(a_res_hold, out_valid && !out_ready, out_valid && $stable(ok) && $stable(word_out) && $stable(length), "result beat changed while stalled")
	`ILIE_ASSERT_NEXT(a_res_follows, in_valid && in_ready, out_valid, "accepted beat gave no result beat")
	`ILIE_ASSERT_NOW(a_fail_zero, out_valid && !ok, word_out == '0, "failed operation returned a nonzero word")
	`ILIE_ASSERT_NOW(a_len_bound, out_valid, (ILIE_DEPTH >= 32) || (int'(length) <= ILIE_DEPTH), "length beyond capacity")

endmodule

bind indexed_list_insert_erase_unit ilie_checker u_ilie_checker (.*);
`default_nettype wire
